// ===== rtl/fov_camera_projection_macros.svh =====
// Assertion macros shared by the checker of the field-of-view projection block.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef FOV_CAMERA_PROJECTION_MACROS_SVH
`define FOV_CAMERA_PROJECTION_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define FCP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fov_camera_projection: implication check failed");

// Implication after a fixed number of cycles, disabled while reset is active.
`define FCP_ASSERT_DLY(lbl, ante, n, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##(n) (cons)) \
        else $error("fov_camera_projection: delayed check failed");

`endif

// ===== rtl/fovcp_pkg.sv =====
// Package of the field-of-view projection block: payload types, register codes,
// pipeline stage map, arctangent table and output clamp. Depends on nothing.
`default_nettype none

package fovcp_pkg;

    // Iterative sections of the pipeline
    localparam int SQRT_STEPS   = 32;
    localparam int NORM_STEPS   = 6;
    localparam int CORDIC_STEPS = 30;
    localparam int DIV_STEPS    = 32;

    // Register index of each pipeline stage
    localparam int ST_SQ    = 0;
    localparam int ST_SUM   = ST_SQ + 1;
    localparam int ST_SQRT0 = ST_SUM + 1;
    localparam int ST_AB    = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_SWAP  = ST_AB + 1;
    localparam int ST_NORM0 = ST_SWAP + 1;
    localparam int ST_COR0  = ST_NORM0 + NORM_STEPS;
    localparam int ST_ANG   = ST_COR0 + CORDIC_STEPS;
    localparam int ST_RD    = ST_ANG + 1;
    localparam int ST_PROD  = ST_RD + 1;
    localparam int ST_DIV0  = ST_PROD + 1;
    localparam int ST_FMUL  = ST_DIV0 + DIV_STEPS;
    localparam int ST_OUT   = ST_FMUL + 1;
    localparam int LATENCY  = ST_OUT + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL_X   = 3'd0,
        CFG_FOCAL_Y   = 3'd1,
        CFG_CENTER_X  = 3'd2,
        CFG_CENTER_Y  = 3'd3,
        CFG_TWICE_TAN = 3'd4,
        CFG_INV_OMEGA = 3'd5
    } t_cfg_idx;

    localparam logic [27:0] RST_FOCAL_X   = 28'd33554432;
    localparam logic [27:0] RST_FOCAL_Y   = 28'd33554432;
    localparam logic [27:0] RST_CENTER_X  = 28'd20971520;
    localparam logic [27:0] RST_CENTER_Y  = 28'd15728640;
    localparam logic [30:0] RST_TWICE_TAN = 31'd18330870;
    localparam logic [30:0] RST_INV_OMEGA = 31'd16777216;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_point_in;

    typedef struct packed {
        logic signed [31:0] pixel_u;
        logic signed [31:0] pixel_v;
        logic               behind_camera;
        logic               saturated;
    } t_pixel_out;

    // Per-point data that rides alongside the datapath
    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic        neg_x;
        logic        neg_y;
        logic [31:0] pz;
        logic        behind;
    } t_side;

    // atan(2^-k) in Q2.30, rounded
    function automatic logic [29:0] atan_q30(input int unsigned k);
        logic [29:0] val;
        case (k)
            0:       val = 30'd843314857;
            1:       val = 30'd497837829;
            2:       val = 30'd263043837;
            3:       val = 30'd133525159;
            4:       val = 30'd67021687;
            5:       val = 30'd33543516;
            6:       val = 30'd16775851;
            7:       val = 30'd8388437;
            8:       val = 30'd4194283;
            9:       val = 30'd2097149;
            default: val = 30'd1 << (30 - k);
        endcase
        return val;
    endfunction

    // Shift tried at each normalize step; together they cover 0..32
    function automatic int unsigned norm_shift(input int unsigned k);
        int unsigned s;
        case (k)
            0:       s = 16;
            1:       s = 8;
            2:       s = 4;
            3:       s = 2;
            default: s = 1;
        endcase
        return s;
    endfunction

    // Apply sign and center, clamp to int32; returns {clamped, value}
    function automatic logic [32:0] clamp_pixel(input logic [35:0] mag, input logic neg,
                                                input logic on_axis, input logic [27:0] ctr);
        logic signed [37:0] term;
        logic signed [37:0] sum;
        logic [32:0]        res;
        term = on_axis ? 38'sd0 : (neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag}));
        sum  = term + $signed({10'd0, ctr});
        if (sum > 38'sd2147483647) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (sum < -38'sd2147483648) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, sum[31:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fov_camera_projection.sv =====
// Top level of the field-of-view lens projection block: a fully pipelined datapath
// from camera-frame point to pixel coordinates. Depends on fovcp_pkg.
//
// Usage:
//  - Input channel: drive i_point and raise i_start; a transaction is taken at each
//    rising edge with i_start high and o_busy low. o_busy is high only while reset
//    is active, so a new point can enter on every cycle.
//  - Result channel: o_done strobes for one cycle with o_result; there is no
//    backpressure, so the receiver must take each result in that cycle.
//  - o_done follows accept through every stage of the fovcp_pkg stage map; throughput is
//    one point per cycle. Depth is set by the 32-step square root, the 30-step
//    CORDIC arctangent and the 32-step radial divide, one step per stage.
//  - Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write one register per cycle;
//    write only while no transaction is in flight. Unknown indexes are dropped.
//  - Reset (synchronous, active low) clears the stage valid bits and loads the
//    default lens registers; points in flight are dropped.
//  - Depth <= 0 gives pixel 0,0 with behind_camera set; results beyond int32 clamp
//    to the rail with saturated set.
`default_nettype none

module fov_camera_projection
    import fovcp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_point_in             i_point,
    output logic                  o_done,
    output t_pixel_out            o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Lens registers
    logic [27:0] r_focal_x, r_focal_y, r_center_x, r_center_y;
    logic [30:0] r_twice_tan, r_inv_omega;

    logic               w_accept;
    logic [LATENCY-1:0] r_vld;
    t_side              n_side;
    t_side              r_side [ST_OUT];

    logic signed [63:0] r_sqx, r_sqy;
    logic [63:0]        r_sum;
    logic [63:0]        r_sq_rem [SQRT_STEPS];
    logic [63:0]        r_sq_res [SQRT_STEPS];
    logic [31:0]        w_rho;
    logic [31:0]        r_rho [ST_AB:ST_OUT-1];
    logic [63:0]        r_a, r_b;
    logic               r_swap [ST_SWAP:ST_ANG-1];
    logic [63:0]        r_hi, r_lo;
    logic [63:0]        r_nhi [NORM_STEPS];
    logic [63:0]        r_nlo [NORM_STEPS];
    logic signed [34:0] r_cx [CORDIC_STEPS];
    logic signed [34:0] r_cy [CORDIC_STEPS];
    logic signed [31:0] r_cz [CORDIC_STEPS];
    logic [30:0]        w_zc;
    logic [30:0]        r_angle;
    logic [61:0]        w_rd_full;
    logic [31:0]        r_rd;
    logic [63:0]        r_prod_x, r_prod_y;
    logic [63:0]        r_dvx [DIV_STEPS];
    logic [63:0]        r_dvy [DIV_STEPS];
    logic [59:0]        r_mx, r_my;
    logic [32:0]        w_u, w_v;
    t_pixel_out         n_res, r_res;

    // Busy only while reset holds the pipeline
    assign o_busy   = ~i_rst_n;
    assign w_accept = i_start & ~o_busy;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x   <= RST_FOCAL_X;
            r_focal_y   <= RST_FOCAL_Y;
            r_center_x  <= RST_CENTER_X;
            r_center_y  <= RST_CENTER_Y;
            r_twice_tan <= RST_TWICE_TAN;
            r_inv_omega <= RST_INV_OMEGA;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FOCAL_X:   r_focal_x   <= i_cfg_data[27:0];
                CFG_FOCAL_Y:   r_focal_y   <= i_cfg_data[27:0];
                CFG_CENTER_X:  r_center_x  <= i_cfg_data[27:0];
                CFG_CENTER_Y:  r_center_y  <= i_cfg_data[27:0];
                CFG_TWICE_TAN: r_twice_tan <= i_cfg_data;
                CFG_INV_OMEGA: r_inv_omega <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits advance one stage per cycle; nothing ever stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], w_accept};
        end
    end

    // Magnitudes, signs and depth ride along the whole pipe
    always_comb begin
        n_side.ax     = i_point.point_x[31] ? (~i_point.point_x + 32'd1) : i_point.point_x;
        n_side.ay     = i_point.point_y[31] ? (~i_point.point_y + 32'd1) : i_point.point_y;
        n_side.neg_x  = i_point.point_x[31];
        n_side.neg_y  = i_point.point_y[31];
        n_side.pz     = i_point.point_z;
        n_side.behind = i_point.point_z[31] || (i_point.point_z == 32'sd0);
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side;
        for (int j = 1; j < ST_OUT; j++) begin
            r_side[j] <= r_side[j-1];
        end
    end

    // Squares, then their sum
    always_ff @(posedge i_clk) begin
        r_sqx <= i_point.point_x * i_point.point_x;
        r_sqy <= i_point.point_y * i_point.point_y;
        r_sum <= $unsigned(r_sqx) + $unsigned(r_sqy);
    end

    // Integer square root, one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] rem_in, res_in;
        logic [64:0] trial;
        if (k == 0) begin : g_first
            assign rem_in = r_sum;
            assign res_in = '0;
        end else begin : g_next
            assign rem_in = r_sq_rem[k-1];
            assign res_in = r_sq_res[k-1];
        end
        assign trial = {1'b0, res_in} + {1'b0, BIT};
        always_ff @(posedge i_clk) begin
            if ({1'b0, rem_in} >= trial) begin
                r_sq_rem[k] <= rem_in - trial[63:0];
                r_sq_res[k] <= (res_in >> 1) + BIT;
            end else begin
                r_sq_rem[k] <= rem_in;
                r_sq_res[k] <= res_in >> 1;
            end
        end
    end

    assign w_rho = r_sq_res[SQRT_STEPS-1][31:0];

    // Arctangent operands rho*T and Z*2^24, then order them
    always_ff @(posedge i_clk) begin
        r_a <= {32'd0, w_rho} * {33'd0, r_twice_tan};
        r_b <= {8'd0, r_side[ST_AB-1].pz, 24'd0};
        r_swap[ST_SWAP] <= r_a > r_b;
        r_hi <= (r_a > r_b) ? r_a : r_b;
        r_lo <= (r_a > r_b) ? r_b : r_a;
        r_rho[ST_AB] <= w_rho;
        for (int j = ST_AB + 1; j < ST_OUT; j++) begin
            r_rho[j] <= r_rho[j-1];
        end
        for (int j = ST_SWAP + 1; j < ST_ANG; j++) begin
            r_swap[j] <= r_swap[j-1];
        end
    end

    // Normalize both operands below 2^32 with a binary shift search: take a shift
    // of S whenever at least S more bits must go
    for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
        localparam int unsigned S = norm_shift(k);
        logic [63:0] hi_in, lo_in;
        if (k == 0) begin : g_first
            assign hi_in = r_hi;
            assign lo_in = r_lo;
        end else begin : g_next
            assign hi_in = r_nhi[k-1];
            assign lo_in = r_nlo[k-1];
        end
        always_ff @(posedge i_clk) begin
            if ((hi_in >> (31 + S)) != 64'd0) begin
                r_nhi[k] <= hi_in >> S;
                r_nlo[k] <= lo_in >> S;
            end else begin
                r_nhi[k] <= hi_in;
                r_nlo[k] <= lo_in;
            end
        end
    end

    // CORDIC vectoring, one iteration per stage
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        logic signed [34:0] x_in, y_in;
        logic signed [31:0] z_in;
        if (k == 0) begin : g_first
            assign x_in = $signed({3'd0, r_nhi[NORM_STEPS-1][31:0]});
            assign y_in = $signed({3'd0, r_nlo[NORM_STEPS-1][31:0]});
            assign z_in = '0;
        end else begin : g_next
            assign x_in = r_cx[k-1];
            assign y_in = r_cy[k-1];
            assign z_in = r_cz[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!y_in[34]) begin
                r_cx[k] <= x_in + (y_in >>> k);
                r_cy[k] <= y_in - (x_in >>> k);
                r_cz[k] <= z_in + $signed({2'b00, atan_q30(k)});
            end else begin
                r_cx[k] <= x_in - (y_in >>> k);
                r_cy[k] <= y_in + (x_in >>> k);
                r_cz[k] <= z_in - $signed({2'b00, atan_q30(k)});
            end
        end
    end

    // Clamp angle at zero, reflect about pi/4 when operands were swapped
    assign w_zc      = r_cz[CORDIC_STEPS-1][31] ? 31'd0 : r_cz[CORDIC_STEPS-1][30:0];
    assign w_rd_full = {31'd0, r_angle} * {31'd0, r_inv_omega};

    always_ff @(posedge i_clk) begin
        r_angle  <= r_swap[ST_ANG-1] ? (HALF_PI_Q30 - w_zc) : w_zc;
        r_rd     <= w_rd_full[61:30];
        r_prod_x <= {32'd0, r_rd} * {32'd0, r_side[ST_PROD-1].ax};
        r_prod_y <= {32'd0, r_rd} * {32'd0, r_side[ST_PROD-1].ay};
    end

    // Restoring divide by rho; the quotient fits 32 bits since |X|,|Y| <= rho
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [63:0] dx_in, dy_in;
        logic [31:0] dvs;
        logic [32:0] tx, ty;
        logic        gex, gey;
        if (k == 0) begin : g_first
            assign dx_in = r_prod_x;
            assign dy_in = r_prod_y;
        end else begin : g_next
            assign dx_in = r_dvx[k-1];
            assign dy_in = r_dvy[k-1];
        end
        assign dvs = r_rho[ST_DIV0+k-1];
        assign tx  = dx_in[63:31];
        assign ty  = dy_in[63:31];
        assign gex = tx >= {1'b0, dvs};
        assign gey = ty >= {1'b0, dvs};
        always_ff @(posedge i_clk) begin
            r_dvx[k] <= {(gex ? (tx[31:0] - dvs) : tx[31:0]), dx_in[30:0], gex};
            r_dvy[k] <= {(gey ? (ty[31:0] - dvs) : ty[31:0]), dy_in[30:0], gey};
        end
    end

    // Focal scaling, then sign, center and clamp
    always_ff @(posedge i_clk) begin
        r_mx <= {32'd0, r_focal_x} * {28'd0, r_dvx[DIV_STEPS-1][31:0]};
        r_my <= {32'd0, r_focal_y} * {28'd0, r_dvy[DIV_STEPS-1][31:0]};
    end

    assign w_u = clamp_pixel(r_mx[59:24], r_side[ST_OUT-1].neg_x,
                             r_rho[ST_OUT-1] == 32'd0, r_center_x);
    assign w_v = clamp_pixel(r_my[59:24], r_side[ST_OUT-1].neg_y,
                             r_rho[ST_OUT-1] == 32'd0, r_center_y);

    always_comb begin
        if (r_side[ST_OUT-1].behind) begin
            n_res.pixel_u       = '0;
            n_res.pixel_v       = '0;
            n_res.behind_camera = 1'b1;
            n_res.saturated     = 1'b0;
        end else begin
            n_res.pixel_u       = $signed(w_u[31:0]);
            n_res.pixel_v       = $signed(w_v[31:0]);
            n_res.behind_camera = 1'b0;
            n_res.saturated     = w_u[32] | w_v[32];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_result = r_res;
    assign o_done   = r_vld[LATENCY-1];

endmodule

`default_nettype wire

// ===== rtl/fcp_checker.sv =====
// Port-level checker for the field-of-view projection block, bound to its top level.
// Depends on fovcp_pkg and fov_camera_projection_macros.svh.
`default_nettype none
`include "fov_camera_projection_macros.svh"

module fcp_checker
    import fovcp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_done,
    input t_pixel_out o_result
);

    // Every accepted transaction completes after the fixed pipeline depth
    `FCP_ASSERT_DLY(a_latency, i_start && !o_busy, LATENCY, o_done)

    // No result without a transaction accepted that many cycles before
    `FCP_ASSERT_IMP(a_no_phantom, o_done, $past(i_start && !o_busy, LATENCY))

    // Points behind the camera give a clean zero result
    `FCP_ASSERT_IMP(a_behind_zero, o_done && o_result.behind_camera, (o_result.pixel_u == 32'sd0) && (o_result.pixel_v == 32'sd0) && !o_result.saturated)

    // A clamped result sits on an int32 rail
    `FCP_ASSERT_IMP(a_sat_rail, o_done && o_result.saturated, (o_result.pixel_u == 32'sh7FFF_FFFF) || (o_result.pixel_u == 32'sh8000_0000) || (o_result.pixel_v == 32'sh7FFF_FFFF) || (o_result.pixel_v == 32'sh8000_0000))

endmodule

bind fov_camera_projection fcp_checker u_fcp_checker (.*);

`default_nettype wire

// ===== tb/fov_camera_projection_tb.sv =====
// Self-checking testbench of the field-of-view lens projection block.
// Depends on fovcp_pkg and fov_camera_projection; predicts each pixel with its own fixed-point
// model and checks every result strobe against it.
`timescale 1ns / 100ps
`default_nettype none

module fov_camera_projection_tb;
    import fovcp_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int DRAIN_CYCLES  = LATENCY + 20;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_POINTS  = 200;

    // Indexes that map to no register; the block must drop writes to them
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_7 = 3'd7;

    localparam longint HALF_PI = 64'd1686629713;
    localparam longint ANGLE_TABLE [30] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    t_point_in             i_point;
    logic                  o_done;
    t_pixel_out            o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fov_camera_projection i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_point    (i_point),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the lens registers, updated on every write we issue
    logic [27:0] lens_fx, lens_fy, lens_cx, lens_cy;
    logic [30:0] lens_tan2, lens_inv_w;

    t_pixel_out pending_pixels[$];
    int         n_points;
    int         n_pixels;
    int         n_errors;
    int         n_behind;
    int         n_clamped;
    int         idle_cycles;
    bit         no_gaps;

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Pixel predictor
    // ------------------------------------------------------------------

    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC of atan2(a, b), Q2.30, b > 0
    function automatic longint lens_angle(input longint unsigned a, input longint unsigned b);
        bit              swap;
        longint unsigned hi, lo;
        longint          x, y, z, dx, dy;
        swap = a > b;
        hi   = swap ? a : b;
        lo   = swap ? b : a;
        z    = 0;
        while (hi >= (64'd1 << 32)) begin
            hi = hi >> 1;
            lo = lo >> 1;
        end
        x = longint'(hi);
        y = longint'(lo);
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ANGLE_TABLE[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ANGLE_TABLE[i];
            end
        end
        if (z < 0) z = 0;
        return swap ? HALF_PI - z : z;
    endfunction

    // Scale one coordinate to the distorted radius, apply focal and center, clamp
    function automatic logic [31:0] place_axis(input longint unsigned rd24, input longint c,
                                               input longint unsigned rho,
                                               input longint unsigned f,
                                               input longint unsigned ctr, inout bit clamped);
        longint          term, r;
        longint unsigned mc, d, m;
        term = 0;
        if (rho != 0) begin
            mc   = (c < 0) ? longint'(-c) : longint'(c);
            d    = (rd24 * mc) / rho;
            m    = (f * d) >> 24;
            term = (c < 0) ? -longint'(m) : longint'(m);
        end
        r = term + longint'(ctr);
        if (r > 64'sd2147483647) begin
            r       = 64'sd2147483647;
            clamped = 1'b1;
        end
        if (r < -64'sd2147483648) begin
            r       = -64'sd2147483648;
            clamped = 1'b1;
        end
        return r[31:0];
    endfunction

    function automatic t_pixel_out project_point(input t_point_in p);
        t_pixel_out      q;
        longint          px, py, pz;
        longint unsigned ax, ay, rho, rd24;
        longint          ang;
        bit              clamped;
        q       = '0;
        clamped = 1'b0;
        px = longint'(p.point_x);
        py = longint'(p.point_y);
        pz = longint'(p.point_z);
        if (pz <= 0) begin
            q.behind_camera = 1'b1;
            return q;
        end
        ax   = (px < 0) ? longint'(-px) : longint'(px);
        ay   = (py < 0) ? longint'(-py) : longint'(py);
        rho  = int_sqrt(ax * ax + ay * ay);
        ang  = lens_angle(rho * longint'(lens_tan2), longint'(pz) << 24);
        rd24 = (longint'(ang) * longint'(lens_inv_w)) >> 30;
        q.pixel_u   = place_axis(rd24, px, rho, lens_fx, lens_cx, clamped);
        q.pixel_v   = place_axis(rd24, py, rho, lens_fy, lens_cy, clamped);
        q.saturated = clamped;
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: compare each strobe with the oldest prediction
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_pixel_out want;
        if (i_rst_n && o_done) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result u=%h v=%h behind=%b sat=%b", $time,
                         o_result.pixel_u, o_result.pixel_v, o_result.behind_camera,
                         o_result.saturated);
                n_errors++;
            end else begin
                want = pending_pixels.pop_front();
                n_pixels++;
                if (o_result.pixel_u !== want.pixel_u) begin
                    $display("%0t: pixel_u expected %h actual %h", $time, want.pixel_u,
                             o_result.pixel_u);
                    n_errors++;
                end
                if (o_result.pixel_v !== want.pixel_v) begin
                    $display("%0t: pixel_v expected %h actual %h", $time, want.pixel_v,
                             o_result.pixel_v);
                    n_errors++;
                end
                if (o_result.behind_camera !== want.behind_camera) begin
                    $display("%0t: behind_camera expected %b actual %b", $time,
                             want.behind_camera, o_result.behind_camera);
                    n_errors++;
                end
                if (o_result.saturated !== want.saturated) begin
                    $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                             o_result.saturated);
                    n_errors++;
                end
                if (want.behind_camera) n_behind++;
                if (want.saturated) n_clamped++;
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (i_start && !o_busy)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_pixels.size());
            $display("fov_camera_projection test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Shared driving tasks (all called at a falling edge)
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one point, hold it until accepted, predict its pixel, then idle a while
    task automatic send_point(input t_point_in p);
        int gap;
        i_start = 1'b1;
        i_point = p;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pending_pixels.push_back(project_point(p));
        n_points++;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_xyz(input int x, input int y, input int z);
        t_point_in p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        send_point(p);
    endtask

    // Drain the pipeline so that a register write cannot affect a point in flight
    task automatic wait_idle();
        i_start = 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_lens(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        case (idx)
            CFG_FOCAL_X:   lens_fx    = value[27:0];
            CFG_FOCAL_Y:   lens_fy    = value[27:0];
            CFG_CENTER_X:  lens_cx    = value[27:0];
            CFG_CENTER_Y:  lens_cy    = value[27:0];
            CFG_TWICE_TAN: lens_tan2  = value;
            CFG_INV_OMEGA: lens_inv_w = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_all(input logic [27:0] fx, input logic [27:0] fy,
                             input logic [27:0] cx, input logic [27:0] cy,
                             input logic [30:0] t2, input logic [30:0] iw);
        write_lens(CFG_FOCAL_X, {3'b0, fx});
        write_lens(CFG_FOCAL_Y, {3'b0, fy});
        write_lens(CFG_CENTER_X, {3'b0, cx});
        write_lens(CFG_CENTER_Y, {3'b0, cy});
        write_lens(CFG_TWICE_TAN, t2);
        write_lens(CFG_INV_OMEGA, iw);
    endtask

    function automatic logic [27:0] pick_reg28(input logic [27:0] dflt);
        case ($urandom_range(0, 5))
            0:       return 28'd0;
            1:       return 28'hFFF_FFFF;
            2:       return dflt;
            3:       return 28'($urandom);
            default: return 28'($urandom_range(1 << 16, 1 << 27) >> $urandom_range(0, 6));
        endcase
    endfunction

    function automatic logic [30:0] pick_reg31(input logic [30:0] dflt);
        case ($urandom_range(0, 5))
            0:       return 31'd1;
            1:       return 31'h7FFF_FFFF;
            2:       return dflt;
            3:       return 31'($urandom);
            default: return 31'($urandom_range(1 << 22, 1 << 27));
        endcase
    endfunction

    // Point generator: mostly plausible scenes, plus raw noise and edge cases
    function automatic t_point_in pick_point();
        t_point_in p;
        int        mode;
        mode = $urandom_range(0, 19);
        p.point_x = $urandom;
        p.point_y = $urandom;
        p.point_z = $urandom;
        if (mode < 12) begin
            p.point_x = $signed(p.point_x) >>> $urandom_range(0, 31);
            p.point_y = $signed(p.point_y) >>> $urandom_range(0, 31);
            p.point_z = {1'b0, p.point_z[30:0]} >> $urandom_range(0, 30);
            if (p.point_z == 0) p.point_z = 1;
        end else if (mode < 14) begin
            p.point_z = -($urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 31));
        end else if (mode < 16) begin
            p.point_x = 0;
            p.point_y = 0;
            if (p.point_z[31]) p.point_z = ~p.point_z;
        end else if (mode < 17) begin
            p.point_x = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            p.point_y = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            p.point_z = $urandom_range(1, 3);
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes under the reset lens
    task automatic test_field_extremes();
        send_xyz(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_xyz(32'sh8000_0000, 32'sh8000_0000, 1);
        send_xyz(32'sh8000_0000, 32'sh7FFF_FFFF, 1);
        send_xyz(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        send_xyz(-32'sh0001_0000, 32'sh0002_0000, 32'sh0010_0000);
        send_xyz(1, -1, 32'sh7FFF_FFFF);
        send_xyz(32'sh7FFF_FFFF, 0, 1);
        send_xyz(0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    endtask

    // Depth at or below zero, and points on the optical axis
    task automatic test_special_points();
        send_xyz(32'sh0001_0000, 32'sh0001_0000, 0);
        send_xyz(32'sh7FFF_FFFF, 32'sh8000_0000, -1);
        send_xyz(5, 7, 32'sh8000_0000);
        send_xyz(0, 0, 1);
        send_xyz(0, 0, 32'sh7FFF_FFFF);
        send_xyz(0, 0, 0);
    endtask

    // Lens register extremes, including zero T and W and dropped indexes
    task automatic test_lens_extremes();
        wait_idle();
        write_all(28'hFFF_FFFF, 28'hFFF_FFFF, 28'hFFF_FFFF, 28'hFFF_FFFF,
                  31'h7FFF_FFFF, 31'h7FFF_FFFF);
        write_lens(CFG_IDX_SPARE_6, 31'h0);
        write_lens(CFG_IDX_SPARE_7, 31'h0);
        send_xyz(32'sh7FFF_FFFF, 32'sh8000_0000, 1);
        send_xyz(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0001_0000);
        send_xyz(0, 0, 32'sh0001_0000);
        wait_idle();
        write_all(28'd0, 28'd0, 28'd0, 28'd0, 31'd0, 31'd0);
        send_xyz(32'sh0010_0000, -32'sh0010_0000, 32'sh0001_0000);
        wait_idle();
        write_all(28'hFFF_FFFF, 28'd1, 28'd0, 28'hFFF_FFFF, 31'd1, 31'h7FFF_FFFF);
        send_xyz(-32'sh0100_0000, 32'sh0100_0000, 1);
        send_xyz(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_8000);
        wait_idle();
        write_all(RST_FOCAL_X, RST_FOCAL_Y, RST_CENTER_X, RST_CENTER_Y,
                  RST_TWICE_TAN, RST_INV_OMEGA);
    endtask

    // Random scenes, with the lens rewritten between phases
    task automatic test_random_scenes();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            if (ph > 0) begin
                write_all(pick_reg28(RST_FOCAL_X), pick_reg28(RST_FOCAL_Y),
                          pick_reg28(RST_CENTER_X), pick_reg28(RST_CENTER_Y),
                          pick_reg31(RST_TWICE_TAN), pick_reg31(RST_INV_OMEGA));
            end
            no_gaps = (ph % 3 == 1);
            for (int k = 0; k < PHASE_POINTS; k++) begin
                if (k == PHASE_POINTS / 2 && ph % 3 == 2) no_gaps = 1'b1;
                send_point(pick_point());
            end
            no_gaps = 1'b0;
        end
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_point     = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_FOCAL_X;
        i_cfg_data  = '0;
        n_points    = 0;
        n_pixels    = 0;
        n_errors    = 0;
        n_behind    = 0;
        n_clamped   = 0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
        lens_fx     = RST_FOCAL_X;
        lens_fy     = RST_FOCAL_Y;
        lens_cx     = RST_CENTER_X;
        lens_cy     = RST_CENTER_Y;
        lens_tan2   = RST_TWICE_TAN;
        lens_inv_w  = RST_INV_OMEGA;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_field_extremes();
        test_special_points();
        test_lens_extremes();
        test_random_scenes();

        // Drain, then give any stray strobe time to show up
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Projected %0d points, checked %0d pixels (%0d behind camera, %0d clamped)",
                 n_points, n_pixels, n_behind, n_clamped);
        $display("Lens registers swept over %0d random settings plus extremes; %0d mismatches",
                 RANDOM_PHASES - 1, n_errors);
        if (n_errors == 0 && pending_pixels.size() == 0) begin
            $display("fov_camera_projection test passed");
        end else begin
            $display("fov_camera_projection test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
